### rtl/smqg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the sphere mesh quad generator.
// Used by every module of the block; depends on nothing else.
package smqg_pkg;

    // Grid limits and register reset values.
    localparam logic [8:0]  MAX_RINGS       = 9'd256;
    localparam logic [8:0]  MAX_SECTORS     = 9'd256;
    localparam logic [8:0]  RING_RESET      = 9'd16;
    localparam logic [8:0]  SECTOR_RESET    = 9'd16;
    localparam logic [15:0] RADIUS_RESET    = 16'd256;

    // Phase and fixed-point constants.
    localparam int          PHASE_W         = 24;
    localparam logic [22:0] QUARTER_TURN    = 23'h400000;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [30:0] ONE_Q30         = 31'h40000000;

    // Pipeline depths of the back end.
    localparam int          PHASE_LAT       = 3;
    localparam int          SINE_LAT        = 16;
    localparam int          SB_DEPTH        = PHASE_LAT + SINE_LAT;

    // Divider sweep length for the grid reciprocals.
    localparam logic [4:0]  DIV_LAST        = 5'd24;

    // Horner divisors of the sine series and their floor(2^32/k) reciprocals.
    localparam logic [6:0]  HORNER_DIV   [4] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [29:0] HORNER_RECIP [4] = '{30'd59652323, 30'd102261126,
                                                 30'd214748364, 30'd715827882};

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_RING_COUNT    = 2'd0,
        CFG_SECTOR_COUNT  = 2'd1,
        CFG_SPHERE_RADIUS = 2'd2
    } cfg_reg_t;

    // Grid setup handed from the setup unit to the datapath.
    typedef struct packed {
        logic        ready;
        logic [8:0]  rings;
        logic [8:0]  sectors;
        logic [15:0] radius;
        logic [23:0] q_th;
        logic [7:0]  rm_th;
        logic [7:0]  d_th;
        logic [24:0] q_ph;
        logic [7:0]  rm_ph;
        logic [7:0]  d_ph;
    } grid_cfg_t;

    // One classified quad waiting in the queue.
    typedef struct packed {
        logic [7:0] ring;
        logic [7:0] sector;
        logic       err;
    } quad_t;

    // Control that travels beside the corner datapath.
    typedef struct packed {
        logic       valid;
        logic [1:0] corner;
        logic       err;
    } corner_sb_t;

    // Arithmetic shift right with rounding half away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[63] ? 64'(-v) : 64'(v);
        m   = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

### rtl/smqg_setup.sv
`timescale 1ns / 1ps
// Configuration registers and the bit-serial divider that derives the
// per-grid phase constants. Depends on smqg_pkg.
module smqg_setup (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output smqg_pkg::grid_cfg_t grid
);
    import smqg_pkg::*;

    logic [8:0]  ring_reg;
    logic [8:0]  sector_reg;
    logic [15:0] radius_reg;
    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [7:0]  rem_th_reg;
    logic [7:0]  rem_ph_reg;
    logic [24:0] quo_th_reg;
    logic [24:0] quo_ph_reg;

    logic [8:0]  rings;
    logic [8:0]  sectors;
    logic [7:0]  d_th;
    logic [7:0]  d_ph;
    logic        restart;
    logic [8:0]  sh_th;
    logic [8:0]  sh_ph;
    logic        ge_th;
    logic        ge_ph;
    logic [7:0]  rem_th_next;
    logic [7:0]  rem_ph_next;

    assign cfg_ready = 1'b1;

    // Counts above the grid limit are used as the limit.
    assign rings   = (ring_reg > MAX_RINGS) ? MAX_RINGS : ring_reg;
    assign sectors = (sector_reg > MAX_SECTORS) ? MAX_SECTORS : sector_reg;
    assign d_th    = 8'(rings - 9'd1);
    assign d_ph    = 8'(sectors - 9'd1);

    // Register writes; a new count restarts the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg   <= RING_RESET;
            sector_reg <= SECTOR_RESET;
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RING_COUNT:    ring_reg   <= cfg_data[8:0];
                CFG_SECTOR_COUNT:  sector_reg <= cfg_data[8:0];
                CFG_SPHERE_RADIUS: radius_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign restart = cfg_valid &&
                     (cfg_index == CFG_RING_COUNT || cfg_index == CFG_SECTOR_COUNT);

    // One restoring step per cycle for 2^23/d_th and 2^24/d_ph, MSB first.
    always_comb
    begin
        sh_th = {rem_th_reg, cnt_reg == 5'd1};
        sh_ph = {rem_ph_reg, cnt_reg == 5'd0};
        ge_th = sh_th >= {1'b0, d_th};
        ge_ph = sh_ph >= {1'b0, d_ph};
        rem_th_next = ge_th ? 8'(sh_th - {1'b0, d_th}) : sh_th[7:0];
        rem_ph_next = ge_ph ? 8'(sh_ph - {1'b0, d_ph}) : sh_ph[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            cnt_reg    <= '0;
            rem_th_reg <= '0;
            rem_ph_reg <= '0;
            quo_th_reg <= '0;
            quo_ph_reg <= '0;
        end
        else if (restart)
        begin
            busy_reg   <= 1'b1;
            cnt_reg    <= '0;
            rem_th_reg <= '0;
            rem_ph_reg <= '0;
            quo_th_reg <= '0;
            quo_ph_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_th_reg <= rem_th_next;
            rem_ph_reg <= rem_ph_next;
            quo_th_reg <= {quo_th_reg[23:0], ge_th};
            quo_ph_reg <= {quo_ph_reg[23:0], ge_ph};
            cnt_reg    <= cnt_reg + 5'd1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign grid.ready   = !busy_reg;
    assign grid.rings   = rings;
    assign grid.sectors = sectors;
    assign grid.radius  = radius_reg;
    assign grid.q_th    = quo_th_reg[23:0];
    assign grid.rm_th   = rem_th_reg;
    assign grid.d_th    = d_th;
    assign grid.q_ph    = quo_ph_reg;
    assign grid.rm_ph   = rem_ph_reg;
    assign grid.d_ph    = d_ph;

endmodule

### rtl/smqg_front.sv
`timescale 1ns / 1ps
// Front end: accepts quad words, flags quads outside the grid and queues them
// for the back end. Depends on smqg_pkg.
module smqg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  smqg_pkg::grid_cfg_t grid,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          ring_index,
    input  logic [7:0]          sector_index,
    output logic                q_valid,
    output smqg_pkg::quad_t     q_head,
    input  logic                q_pop
);
    import smqg_pkg::*;

    quad_t      mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic       push;
    logic       err;

    assign in_ready = (count_reg != 3'd4) && grid.ready;
    assign push     = in_valid && in_ready;
    assign q_valid  = count_reg != 3'd0;
    assign q_head   = mem[rd_ptr_reg];

    // Quad lies outside the grid when either corner row or column overruns.
    assign err = (grid.rings < 9'd2) || (grid.sectors < 9'd2) ||
                 ({2'b0, ring_index} + 10'd2 > {1'b0, grid.rings}) ||
                 ({2'b0, sector_index} + 10'd2 > {1'b0, grid.sectors});

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{ring: ring_index, sector: sector_index, err: err};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 3'd1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 3'd1;
            end
        end
    end

endmodule

### rtl/smqg_sine.sv
`timescale 1ns / 1ps
// Pipelined Q30 sine of a 24-bit turn phase: quarter-wave fold, then a
// Horner series with exact constant division. Depends on smqg_pkg.
module smqg_sine (
    input  logic                    clk,
    input  logic                    en,
    input  logic [23:0]             phase,
    output logic signed [31:0]      sine
);
    import smqg_pkg::*;

    logic [22:0] f_reg;
    logic        neg_pipe [1:16];
    logic [30:0] x_pipe   [2:15];
    logic [31:0] x2_pipe  [3:12];
    logic [31:0] w_reg    [4];
    logic [31:0] wd_reg   [4];
    logic [29:0] qm_reg   [4];
    logic [30:0] t_reg    [4];
    logic [30:0] s_reg;

    logic [22:0] fold;
    logic [53:0] x_prod;
    logic [61:0] x2_prod;
    logic [30:0] t_src    [4];
    logic [62:0] w_prod   [4];
    logic [61:0] qm_prod  [4];
    logic [32:0] rem      [4];
    logic [30:0] t_next   [4];
    logic [61:0] s_prod;

    // Fold the phase into the first quarter wave.
    assign fold = phase[22] ? 23'(QUARTER_TURN - {1'b0, phase[21:0]}) : {1'b0, phase[21:0]};

    assign x_prod  = 54'(f_reg) * 54'(HALF_PI_Q30);
    assign x2_prod = 62'(x_pipe[2]) * 62'(x_pipe[2]);
    assign s_prod  = 62'(x_pipe[15]) * 62'(t_reg[3]);

    // Horner steps: t = 1 - floor(floor(x2*t)/k), division by reciprocal.
    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            t_src[g]   = (g == 0) ? ONE_Q30 : t_reg[(g == 0) ? 0 : g - 1];
            w_prod[g]  = 63'(x2_pipe[3 + 3 * g]) * 63'(t_src[g]);
            qm_prod[g] = 62'(w_reg[g]) * 62'(HORNER_RECIP[g]);
            rem[g]     = 33'(wd_reg[g]) - 33'(qm_reg[g]) * 33'(HORNER_DIV[g]);
            t_next[g]  = ONE_Q30 - 31'(qm_reg[g] + 30'(rem[g] >= 33'(HORNER_DIV[g])));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg       <= fold;
            neg_pipe[1] <= phase[23];
            x_pipe[2]   <= 31'((x_prod + 54'(1 << 21)) >> 22);
            x2_pipe[3]  <= 32'((x2_prod + 62'(1 << 29)) >> 30);
            for (int s = 2; s <= 16; s++)
            begin
                neg_pipe[s] <= neg_pipe[s - 1];
            end
            for (int s = 3; s <= 15; s++)
            begin
                x_pipe[s] <= x_pipe[s - 1];
            end
            for (int s = 4; s <= 12; s++)
            begin
                x2_pipe[s] <= x2_pipe[s - 1];
            end
            for (int g = 0; g < 4; g++)
            begin
                w_reg[g]  <= 32'(w_prod[g] >> 30);
                wd_reg[g] <= w_reg[g];
                qm_reg[g] <= 30'(qm_prod[g] >> 32);
                t_reg[g]  <= t_next[g];
            end
            s_reg <= 31'(s_prod >> 30);
        end
    end

    // Lower half of the turn keeps the sign, upper half negates.
    assign sine = neg_pipe[16] ? -$signed({1'b0, s_reg}) : $signed({1'b0, s_reg});

endmodule

### rtl/smqg_back.sv
`timescale 1ns / 1ps
// Back end: walks each queued quad through its four corners, forms the
// angle phases, sines and cosines, and the scaled vertex and normal.
// Depends on smqg_pkg and smqg_sine.
module smqg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  smqg_pkg::grid_cfg_t grid,
    input  logic                q_valid,
    input  smqg_pkg::quad_t     q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          corner_number,
    output logic signed [17:0]  vertex_x,
    output logic signed [17:0]  vertex_y,
    output logic signed [17:0]  vertex_z,
    output logic signed [15:0]  normal_x,
    output logic signed [15:0]  normal_y,
    output logic signed [15:0]  normal_z,
    output logic                last_corner,
    output logic                index_error
);
    import smqg_pkg::*;

    // Corner sequencer.
    quad_t       cur_reg;
    logic        cur_valid_reg;
    logic [1:0]  corner_reg;

    // Phase stages.
    logic [23:0] rq_th_reg;
    logic [23:0] rq_ph_reg;
    logic [16:0] v_th_reg;
    logic [16:0] v_ph_reg;
    logic [23:0] rq_th2_reg;
    logic [23:0] rq_ph2_reg;
    logic [16:0] v_th2_reg;
    logic [16:0] v_ph2_reg;
    logic [17:0] q0_th_reg;
    logic [17:0] q0_ph_reg;
    logic [23:0] th_reg;
    logic [23:0] ph_reg;

    corner_sb_t  sb_reg [SB_DEPTH];
    corner_sb_t  sb_n1_reg;
    logic signed [31:0] n_reg [3];

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  corner_out_reg;
    logic        last_out_reg;
    logic        err_out_reg;
    logic signed [17:0] vx_reg;
    logic signed [17:0] vy_reg;
    logic signed [17:0] vz_reg;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;

    logic        en;
    logic        issue;
    logic [8:0]  ri;
    logic [8:0]  si;
    logic [32:0] rq_th_full;
    logic [33:0] rq_ph_full;
    logic [33:0] q0_th_prod;
    logic [33:0] q0_ph_prod;
    logic [25:0] qd_th;
    logic [25:0] qd_ph;
    logic [17:0] rem_th;
    logic [17:0] rem_ph;
    logic [23:0] th_cos_in;
    logic [23:0] ph_cos_in;
    logic signed [31:0] sin_th;
    logic signed [31:0] cos_th;
    logic signed [31:0] sin_ph;
    logic signed [31:0] cos_ph;
    logic signed [63:0] p0;
    logic signed [63:0] p2;
    logic signed [63:0] vp [3];
    logic signed [16:0] radius_s;

    // The whole pipeline moves unless a finished word waits at the output.
    assign en    = !out_valid_reg || out_ready;
    assign issue = cur_valid_reg && en;
    assign q_pop = q_valid && (!cur_valid_reg || (issue && corner_reg == 2'd3));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            corner_reg    <= '0;
        end
        else if (q_pop)
        begin
            cur_valid_reg <= 1'b1;
            corner_reg    <= '0;
        end
        else if (issue)
        begin
            corner_reg <= corner_reg + 2'd1;
            if (corner_reg == 2'd3)
            begin
                cur_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
    end

    // Grid point of this corner.
    assign ri = {1'b0, cur_reg.ring} + {8'b0, corner_reg[1]};
    assign si = {1'b0, cur_reg.sector} + {8'b0, corner_reg == 2'd1 || corner_reg == 2'd2};

    // Phase = i*Q + floor((i*Rm + d/2)/d), the inner quotient by reciprocal.
    assign rq_th_full = 33'(ri) * 33'(grid.q_th);
    assign rq_ph_full = 34'(si) * 34'(grid.q_ph);
    assign q0_th_prod = 34'(v_th_reg) * 34'(grid.q_th[23:7]);
    assign q0_ph_prod = 34'(v_ph_reg) * 34'(grid.q_ph[24:8]);
    assign qd_th      = 26'(q0_th_reg) * 26'(grid.d_th);
    assign qd_ph      = 26'(q0_ph_reg) * 26'(grid.d_ph);
    assign rem_th     = 18'(v_th2_reg) - qd_th[17:0];
    assign rem_ph     = 18'(v_ph2_reg) - qd_ph[17:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rq_th_reg  <= rq_th_full[23:0];
            rq_ph_reg  <= rq_ph_full[23:0];
            v_th_reg   <= 17'(ri) * 17'(grid.rm_th) + 17'(grid.d_th[7:1]);
            v_ph_reg   <= 17'(si) * 17'(grid.rm_ph) + 17'(grid.d_ph[7:1]);
            rq_th2_reg <= rq_th_reg;
            rq_ph2_reg <= rq_ph_reg;
            v_th2_reg  <= v_th_reg;
            v_ph2_reg  <= v_ph_reg;
            q0_th_reg  <= 18'(q0_th_prod >> 16);
            q0_ph_reg  <= 18'(q0_ph_prod >> 16);
            th_reg     <= rq_th2_reg + 24'(q0_th_reg) + 24'(rem_th >= 18'(grid.d_th));
            ph_reg     <= rq_ph2_reg + 24'(q0_ph_reg) + 24'(rem_ph >= 18'(grid.d_ph));
        end
    end

    // Cosine is the sine a quarter turn later.
    assign th_cos_in = th_reg + 24'h400000;
    assign ph_cos_in = ph_reg + 24'h400000;

    smqg_sine u_sin_th (.clk(clk), .en(en), .phase(th_reg),    .sine(sin_th));
    smqg_sine u_cos_th (.clk(clk), .en(en), .phase(th_cos_in), .sine(cos_th));
    smqg_sine u_sin_ph (.clk(clk), .en(en), .phase(ph_reg),    .sine(sin_ph));
    smqg_sine u_cos_ph (.clk(clk), .en(en), .phase(ph_cos_in), .sine(cos_ph));

    // Corner control runs beside the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SB_DEPTH; i++)
            begin
                sb_reg[i] <= '0;
            end
            sb_n1_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sb_reg[0] <= '{valid: issue, corner: corner_reg, err: cur_reg.err};
            for (int i = 1; i < SB_DEPTH; i++)
            begin
                sb_reg[i] <= sb_reg[i - 1];
            end
            sb_n1_reg     <= sb_reg[SB_DEPTH - 1];
            out_valid_reg <= sb_n1_reg.valid;
        end
    end

    // Normal components in Q30.
    assign p0 = cos_ph * sin_th;
    assign p2 = sin_ph * sin_th;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= 32'(round_shift(p0, 30));
            n_reg[1] <= -cos_th;
            n_reg[2] <= 32'(round_shift(p2, 30));
        end
    end

    // Scale by the radius and round to the output formats.
    assign radius_s = $signed({1'b0, grid.radius});

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            vp[c] = radius_s * n_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            corner_out_reg <= sb_n1_reg.corner;
            last_out_reg   <= sb_n1_reg.corner == 2'd3;
            err_out_reg    <= sb_n1_reg.err;
            if (sb_n1_reg.err)
            begin
                vx_reg <= '0;
                vy_reg <= '0;
                vz_reg <= '0;
                nx_reg <= '0;
                ny_reg <= '0;
                nz_reg <= '0;
            end
            else
            begin
                vx_reg <= 18'(round_shift(vp[0], 30));
                vy_reg <= 18'(round_shift(vp[1], 30));
                vz_reg <= 18'(round_shift(vp[2], 30));
                nx_reg <= 16'(round_shift(64'(n_reg[0]), 16));
                ny_reg <= 16'(round_shift(64'(n_reg[1]), 16));
                nz_reg <= 16'(round_shift(64'(n_reg[2]), 16));
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign corner_number = corner_out_reg;
    assign last_corner   = last_out_reg;
    assign index_error   = err_out_reg;
    assign vertex_x      = vx_reg;
    assign vertex_y      = vy_reg;
    assign vertex_z      = vz_reg;
    assign normal_x      = nx_reg;
    assign normal_y      = ny_reg;
    assign normal_z      = nz_reg;

endmodule

### rtl/sphere_mesh_quad_generator_top.sv
`timescale 1ns / 1ps
// Sphere mesh quad generator: one quad word in, four corner words out.
// Throughput is one corner word per cycle while the output is not stalled by
// out_ready, set by the single corner issue port of the back end.
// After reset and after every ring or sector count write, a divider sweep
// runs with in_ready low; registers reset to 16 rings, 16 sectors, radius 256.
module sphere_mesh_quad_generator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         ring_index,
    input  logic [7:0]         sector_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         corner_number,
    output logic signed [17:0] vertex_x,
    output logic signed [17:0] vertex_y,
    output logic signed [17:0] vertex_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic               last_corner,
    output logic               index_error
);
    import smqg_pkg::*;

    grid_cfg_t grid;
    logic      q_valid;
    quad_t     q_head;
    logic      q_pop;

    // Registers and phase constants.
    smqg_setup u_setup (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .grid(grid)
    );

    // Accept and classify quads.
    smqg_front u_front (
        .clk(clk), .rst_n(rst_n), .grid(grid),
        .in_valid(in_valid), .in_ready(in_ready),
        .ring_index(ring_index), .sector_index(sector_index),
        .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
    );

    // Corner datapath.
    smqg_back u_back (
        .clk(clk), .rst_n(rst_n), .grid(grid),
        .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
        .out_valid(out_valid), .out_ready(out_ready),
        .corner_number(corner_number),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .last_corner(last_corner), .index_error(index_error)
    );

endmodule

### dv/tb_sphere_mesh_quad_generator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sphere mesh quad generator top level.
// Depends only on rtl/smqg_pkg.sv and the top module; carries its own corner predictor.
module tb_sphere_mesh_quad_generator_top;
    import smqg_pkg::*;

    localparam logic [1:0]  CFG_UNMAPPED = 2'd3;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [31:0] PHASE_MASK   = 32'h00FFFFFF;
    localparam logic [31:0] QTURN        = 32'h00400000;
    localparam longint      Q30_ONE      = 64'd1 << 30;
    localparam longint      HALF_PI      = 64'd1686629713;

    // One corner word as it leaves the block.
    typedef struct packed {
        logic [1:0]         corner;
        logic signed [17:0] vx;
        logic signed [17:0] vy;
        logic signed [17:0] vz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               last;
        logic               err;
    } corner_word_t;

    // One row of the directed table; typed rows carry a known out-of-grid answer.
    typedef struct {
        logic [7:0] ring;
        logic [7:0] sector;
        bit         typed_err;
    } quad_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         ring_index;
    logic [7:0]         sector_index;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         corner_number;
    logic signed [17:0] vertex_x;
    logic signed [17:0] vertex_y;
    logic signed [17:0] vertex_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last_corner;
    logic               index_error;

    // Predictor copy of the registers.
    logic [8:0]  grid_rings;
    logic [8:0]  grid_sectors;
    logic [15:0] grid_radius;

    corner_word_t pending_corners[$];
    int          mismatches;
    int          quads_sent;
    int          corners_seen;
    int          cycles;
    bit          quiet;

    sphere_mesh_quad_generator_top DUT (.*);

    // Clock source.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rounding shift, half away from zero.
    function automatic longint shift_round(longint v, int sh);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Sine over a quarter wave, Q30, by the truncated Horner series.
    function automatic longint unsigned quarter_wave_sine(longint unsigned f);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        x  = (f * HALF_PI + (64'd1 << 21)) >> 22;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    // Full-turn sine of a 24-bit phase.
    function automatic longint phase_sine(logic [31:0] p);
        logic [31:0] q;
        logic [31:0] f;
        longint      m;
        p = p & PHASE_MASK;
        q = p >> 22;
        f = p & (QTURN - 1);
        if (q[0])
            f = QTURN - f;
        m = longint'(quarter_wave_sine(f));
        return (q >= 2) ? -m : m;
    endfunction

    function automatic longint phase_cosine(logic [31:0] p);
        return phase_sine((p & PHASE_MASK) + QTURN);
    endfunction

    // Grid index to phase in 2^-24 turn units.
    function automatic logic [31:0] grid_phase(int unsigned idx, int sh, int unsigned den);
        longint unsigned num;
        num = (longint'(idx) << sh) + den / 2;
        return 32'((num / den) & PHASE_MASK);
    endfunction

    // Works out the four corners of one quad under the current registers.
    task automatic predict_quad(logic [7:0] r, logic [7:0] s);
        int unsigned  rings;
        int unsigned  sectors;
        bit           err;
        longint       n[3];
        longint       st;
        logic [31:0]  th;
        logic [31:0]  ph;
        corner_word_t w;
        rings   = (grid_rings > 256) ? 256 : grid_rings;
        sectors = (grid_sectors > 256) ? 256 : grid_sectors;
        err = rings < 2 || sectors < 2 || r + 2 > rings || s + 2 > sectors;
        for (int k = 0; k < 4; k++)
        begin
            n = '{0, 0, 0};
            if (!err)
            begin
                th   = grid_phase(r + (k >= 2), 23, rings - 1);
                ph   = grid_phase(s + (k == 1 || k == 2), 24, sectors - 1);
                st   = phase_sine(th);
                n[0] = shift_round(phase_cosine(ph) * st, 30);
                n[1] = -phase_cosine(th);
                n[2] = shift_round(phase_sine(ph) * st, 30);
            end
            w.corner = 2'(k);
            w.vx   = 18'(shift_round(longint'(grid_radius) * n[0], 30));
            w.vy   = 18'(shift_round(longint'(grid_radius) * n[1], 30));
            w.vz   = 18'(shift_round(longint'(grid_radius) * n[2], 30));
            w.nx   = 16'(shift_round(n[0], 16));
            w.ny   = 16'(shift_round(n[1], 16));
            w.nz   = 16'(shift_round(n[2], 16));
            w.last = (k == 3);
            w.err  = err;
            pending_corners = {pending_corners, w};
        end
    endtask

    // Sends one quad word, with an optional idle burst in front.
    task automatic send_quad(logic [7:0] r, logic [7:0] s, bit typed_err);
        corner_word_t w;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid     = 1'b1;
        ring_index   = r;
        sector_index = s;
        do @(posedge clk); while (!in_ready);
        if (typed_err)
        begin
            for (int k = 0; k < 4; k++)
            begin
                w = '0;
                w.corner = 2'(k);
                w.last = (k == 3);
                w.err = 1'b1;
                pending_corners = {pending_corners, w};
            end
        end
        else
            predict_quad(r, s);
        quads_sent++;
        @(negedge clk);
    endtask

    // Writes one register once the block has drained.
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        in_valid = 1'b0;
        while (pending_corners.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_RING_COUNT:    grid_rings = data[8:0];
            CFG_SECTOR_COUNT:  grid_sectors = data[8:0];
            CFG_SPHERE_RADIUS: grid_radius = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random quads: mostly inside the grid, some anywhere.
    task automatic random_quads(int count);
        int unsigned rings;
        int unsigned sectors;
        logic [7:0]  r;
        logic [7:0]  s;
        rings   = (grid_rings > 256) ? 256 : grid_rings;
        sectors = (grid_sectors > 256) ? 256 : grid_sectors;
        for (int i = 0; i < count; i++)
        begin
            r = 8'($urandom_range(0, 255));
            s = 8'($urandom_range(0, 255));
            if (rings >= 2 && sectors >= 2 && $urandom_range(0, 9) < 8)
            begin
                r = 8'($urandom_range(0, rings - 2));
                s = 8'($urandom_range(0, sectors - 2));
            end
            send_quad(r, s, 1'b0);
        end
    endtask

    // Receiver stall bursts, changed at the falling edge.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    // Corner word checker and cycle limit.
    always @(posedge clk)
    begin
        corner_word_t got;
        corner_word_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_sphere_mesh_quad_generator_top: done, errors");
            $finish;
        end
        else if (rst_n && out_valid && out_ready)
        begin
            got = '{corner_number, vertex_x, vertex_y, vertex_z,
                    normal_x, normal_y, normal_z, last_corner, index_error};
            corners_seen++;
            if (pending_corners.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected corner word %p", got);
            end
            else
            begin
                want = pending_corners.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("corner mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    // Directed table at the reset grid (16 x 16).
    quad_row_t directed_quads[12] = '{
        '{8'd0,   8'd0,   1'b0}, '{8'd14,  8'd14,  1'b0}, '{8'd0,   8'd14,  1'b0},
        '{8'd14,  8'd0,   1'b0}, '{8'd7,   8'd3,   1'b0}, '{8'd3,   8'd11,  1'b0},
        '{8'd15,  8'd0,   1'b1}, '{8'd0,   8'd15,  1'b1}, '{8'd255, 8'd255, 1'b1},
        '{8'd128, 8'd5,   1'b1}, '{8'd5,   8'd170, 1'b1}, '{8'd85,  8'd85,  1'b1}
    };

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RING_COUNT;
        cfg_data = '0;
        in_valid = 1'b0;
        ring_index = '0;
        sector_index = '0;
        grid_rings = RING_RESET;
        grid_sectors = SECTOR_RESET;
        grid_radius = RADIUS_RESET;
        mismatches = 0;
        quads_sent = 0;
        corners_seen = 0;
        cycles = 0;
        quiet = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_quads[i])
            send_quad(directed_quads[i].ring, directed_quads[i].sector,
                      directed_quads[i].typed_err);

        // Smallest grid, full-scale radius.
        write_reg(CFG_RING_COUNT, 16'd2);
        write_reg(CFG_SECTOR_COUNT, 16'd2);
        write_reg(CFG_SPHERE_RADIUS, 16'hFFFF);
        send_quad(8'd0, 8'd0, 1'b0);
        send_quad(8'd1, 8'd0, 1'b0);
        random_quads(20);

        // Largest grid, zero radius, then a mid radius.
        write_reg(CFG_RING_COUNT, 16'd256);
        write_reg(CFG_SECTOR_COUNT, 16'd256);
        write_reg(CFG_SPHERE_RADIUS, 16'd0);
        send_quad(8'd254, 8'd254, 1'b0);
        send_quad(8'd255, 8'd0, 1'b0);
        random_quads(40);
        write_reg(CFG_SPHERE_RADIUS, 16'h8000);
        random_quads(60);

        // Counts above the maximum are clamped; high data bits are dropped.
        write_reg(CFG_RING_COUNT, 16'd511);
        write_reg(CFG_SECTOR_COUNT, 16'hFE2C);
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        random_quads(60);

        // Counts below two put every quad off the grid.
        write_reg(CFG_RING_COUNT, 16'd0);
        write_reg(CFG_SECTOR_COUNT, 16'd1);
        random_quads(20);
        write_reg(CFG_RING_COUNT, 16'd1);
        write_reg(CFG_SECTOR_COUNT, 16'd2);
        random_quads(10);

        // Random grids and radii.
        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_RING_COUNT, 16'($urandom_range(2, 256)));
            write_reg(CFG_SECTOR_COUNT, 16'($urandom_range(2, 256)));
            write_reg(CFG_SPHERE_RADIUS, 16'($urandom_range(0, 65535)));
            random_quads(35);
        end

        // Final stretch at full rate on both sides.
        write_reg(CFG_RING_COUNT, 16'd16);
        write_reg(CFG_SECTOR_COUNT, 16'd64);
        quiet = 1'b1;
        random_quads(40);
        in_valid = 1'b0;

        while (pending_corners.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d quads over twelve grid and radius settings; checked %0d corner words.",
                 quads_sent, corners_seen);
        $display("Mismatches: %0d", mismatches + pending_corners.size());
        if (mismatches == 0 && pending_corners.size() == 0)
            $display("tb_sphere_mesh_quad_generator_top: done, clean");
        else
            $display("tb_sphere_mesh_quad_generator_top: done, errors");
        $finish;
    end

endmodule

### files.f
rtl/smqg_pkg.sv
rtl/smqg_setup.sv
rtl/smqg_front.sv
rtl/smqg_sine.sv
rtl/smqg_back.sv
rtl/sphere_mesh_quad_generator_top.sv
dv/tb_sphere_mesh_quad_generator_top.sv
